// ----- rtl/assert_macros.svh -----
// assertion macros included by the huffman frequency merge top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every rising clock edge out of reset
`define HFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define HFM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define HFM_ASSERT(lbl, prop, msg)
`define HFM_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/hfm_pkg.sv -----
// shared types, constants and helpers for the huffman frequency merge block
package hfm_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int COUNT_WIDTH = 32;

    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 9;
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int OUT_COUNT_W = 32;
    localparam int OUT_LEN_W   = 9;
    localparam int ENTRY_W     = ID_W + COUNT_WIDTH;

    localparam logic [ID_W-1:0] FIRST_INTERNAL_ID = 9'd256;
    localparam logic [ID_W-1:0] LAST_INTERNAL_ID  = 9'd511;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW_LEAF = 3'd0,
        ST_COUNTED  = 3'd1,
        ST_MERGED   = 3'd2,
        ST_TOO_FEW  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [COUNT_WIDTH-1:0] cnt;
    } t_entry;

    // low bits of a count for the result port
    function automatic logic [OUT_COUNT_W-1:0] out_count(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return w[OUT_COUNT_W-1:0];
    endfunction

endpackage

// ----- rtl/hfm_ram.sv -----
// generic single write port, single read port ram with registered read
module hfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/huffman_frequency_merge.sv -----
// top level of the huffman frequency merge block: ordered node list with count and merge
//
// The node list lives in one ram, stored back to front: the front of the list is the
// highest used address, so putting a node at the front is an append. Every count item
// and every merge of two or more entries walks the stored entries one per cycle through
// the ram read port with a single shared compare stage. A count item makes one scan for
// the matching leaf, then the update. A merge makes the two-minimum scan, then the
// compaction sweep that closes the two holes behind the removed entries; a merge with
// fewer than two entries skips both and goes straight to its result. The input is
// stalled for the whole time an item is being worked; the result then sits in an output
// register, so the next item is taken while a result still waits. No clearing pass is
// needed after reset: only the first length entries are ever read.
module huffman_frequency_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [hfm_pkg::SYM_W-1:0]     i_symbol,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hfm_pkg::STATUS_W-1:0]  o_status,
    output logic [hfm_pkg::ID_W-1:0]      o_new_id,
    output logic [hfm_pkg::ID_W-1:0]      o_left_id,
    output logic [hfm_pkg::ID_W-1:0]      o_right_id,
    output logic [hfm_pkg::OUT_COUNT_W-1:0] o_count,
    output logic [hfm_pkg::OUT_LEN_W-1:0] o_list_length
);
    import hfm_pkg::*;

    // control state
    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [ID_W-1:0]        r_next_id, n_next_id;
    logic                   r_dv, n_dv;
    logic                   r_a_vld, n_a_vld;
    logic                   r_b_vld, n_b_vld;
    logic                   r_o_valid, n_o_valid;

    // working payload
    logic                   r_mode, n_mode;
    logic [SYM_W-1:0]       r_sym, n_sym;
    logic [LEN_W-1:0]       r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]       r_dv_idx, n_dv_idx;
    logic [IDX_W-1:0]       r_a_idx, n_a_idx;
    logic [ID_W-1:0]        r_a_id, n_a_id;
    logic [COUNT_WIDTH-1:0] r_a_cnt, n_a_cnt;
    logic [IDX_W-1:0]       r_b_idx, n_b_idx;
    logic [ID_W-1:0]        r_b_id, n_b_id;
    logic [COUNT_WIDTH-1:0] r_b_cnt, n_b_cnt;
    logic [IDX_W-1:0]       r_lo, n_lo;
    logic [IDX_W-1:0]       r_hi, n_hi;

    // result of the item in work
    t_status                r_res_status, n_res_status;
    logic [ID_W-1:0]        r_res_new_id, n_res_new_id;
    logic [ID_W-1:0]        r_res_left, n_res_left;
    logic [ID_W-1:0]        r_res_right, n_res_right;
    logic [COUNT_WIDTH-1:0] r_res_count, n_res_count;

    // output register
    t_status                r_o_status, n_o_status;
    logic [ID_W-1:0]        r_o_new_id, n_o_new_id;
    logic [ID_W-1:0]        r_o_left, n_o_left;
    logic [ID_W-1:0]        r_o_right, n_o_right;
    logic [OUT_COUNT_W-1:0] r_o_count, n_o_count;
    logic [OUT_LEN_W-1:0]   r_o_len, n_o_len;

    // ram port
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    t_entry                 ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    t_entry                 rd_entry;

    // helpers
    logic                   in_acc;
    logic                   out_free;
    logic                   scan_end;
    logic [COUNT_WIDTH:0]   sum_full;
    logic [COUNT_WIDTH-1:0] sum_sat;
    logic [COUNT_WIDTH-1:0] inc_sat;

    hfm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_out_stall;
    assign scan_end = (r_rd_idx >= r_len) && !r_dv;
    assign sum_full = {1'b0, r_a_cnt} + {1'b0, r_b_cnt};
    assign sum_sat  = sum_full[COUNT_WIDTH] ? COUNT_MAX : sum_full[COUNT_WIDTH-1:0];
    assign inc_sat  = (r_a_cnt == COUNT_MAX) ? r_a_cnt : r_a_cnt + COUNT_WIDTH'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_mode && (r_len < LEN_W'(2))) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = r_mode ? S_SWEEP : S_DONE;
                end
            end
            S_SWEEP: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, ram control and result
    always_comb begin
        n_len        = r_len;
        n_next_id    = r_next_id;
        n_dv         = r_dv;
        n_a_vld      = r_a_vld;
        n_b_vld      = r_b_vld;
        n_o_valid    = r_o_valid && i_out_stall;
        n_mode       = r_mode;
        n_sym        = r_sym;
        n_rd_idx     = r_rd_idx;
        n_dv_idx     = r_dv_idx;
        n_a_idx      = r_a_idx;
        n_a_id       = r_a_id;
        n_a_cnt      = r_a_cnt;
        n_b_idx      = r_b_idx;
        n_b_id       = r_b_id;
        n_b_cnt      = r_b_cnt;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_status = r_res_status;
        n_res_new_id = r_res_new_id;
        n_res_left   = r_res_left;
        n_res_right  = r_res_right;
        n_res_count  = r_res_count;
        n_o_status   = r_o_status;
        n_o_new_id   = r_o_new_id;
        n_o_left     = r_o_left;
        n_o_right    = r_o_right;
        n_o_count    = r_o_count;
        n_o_len      = r_o_len;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = r_rd_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode       = i_mode;
                    n_sym        = i_symbol;
                    n_rd_idx     = '0;
                    n_dv         = 1'b0;
                    n_a_vld      = 1'b0;
                    n_b_vld      = 1'b0;
                    n_res_status = i_mode ? ST_TOO_FEW : ST_NEW_LEAF;
                    n_res_new_id = i_mode ? '0 : ID_W'(i_symbol);
                    n_res_left   = '0;
                    n_res_right  = '0;
                    n_res_count  = '0;
                end
            end

            S_SCAN: begin
                // issue one read per cycle
                if (r_rd_idx < r_len) begin
                    n_rd_idx = r_rd_idx + LEN_W'(1);
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                // compare the returned entry
                if (r_dv) begin
                    if (!r_mode) begin
                        if (rd_entry.id == ID_W'(r_sym)) begin
                            n_a_vld = 1'b1;
                            n_a_idx = r_dv_idx;
                            n_a_cnt = rd_entry.cnt;
                        end
                    end else if (!r_a_vld || (rd_entry.cnt <= r_a_cnt)) begin
                        // later address is nearer the front, so it wins ties
                        n_b_vld = r_a_vld;
                        n_b_idx = r_a_idx;
                        n_b_id  = r_a_id;
                        n_b_cnt = r_a_cnt;
                        n_a_vld = 1'b1;
                        n_a_idx = r_dv_idx;
                        n_a_id  = rd_entry.id;
                        n_a_cnt = rd_entry.cnt;
                    end else if (!r_b_vld || (rd_entry.cnt <= r_b_cnt)) begin
                        n_b_vld = 1'b1;
                        n_b_idx = r_dv_idx;
                        n_b_id  = rd_entry.id;
                        n_b_cnt = rd_entry.cnt;
                    end
                end
                // scan over: settle count item or prepare the sweep
                if (scan_end) begin
                    if (!r_mode) begin
                        if (r_a_vld) begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_a_idx;
                            ram_wdata    = '{id: ID_W'(r_sym), cnt: inc_sat};
                            n_res_status = ST_COUNTED;
                            n_res_count  = inc_sat;
                        end else if (r_len == LEN_W'(MAX_ENTRIES)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_len[IDX_W-1:0];
                            ram_wdata    = '{id: ID_W'(r_sym), cnt: COUNT_WIDTH'(1)};
                            n_len        = r_len + LEN_W'(1);
                            n_res_status = ST_NEW_LEAF;
                            n_res_count  = COUNT_WIDTH'(1);
                        end
                    end else begin
                        n_lo         = (r_a_idx < r_b_idx) ? r_a_idx : r_b_idx;
                        n_hi         = (r_a_idx < r_b_idx) ? r_b_idx : r_a_idx;
                        n_rd_idx     = LEN_W'((r_a_idx < r_b_idx) ? r_a_idx : r_b_idx)
                                       + LEN_W'(1);
                        n_dv         = 1'b0;
                        n_res_status = ST_MERGED;
                        n_res_new_id = r_next_id;
                        n_res_left   = r_a_id;
                        n_res_right  = r_b_id;
                        n_res_count  = sum_sat;
                    end
                end
            end

            S_SWEEP: begin
                // read above the lower hole
                if (r_rd_idx < r_len) begin
                    n_rd_idx = r_rd_idx + LEN_W'(1);
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                // move each survivor down past the holes below it
                if (r_dv && (r_dv_idx != r_hi)) begin
                    ram_we    = 1'b1;
                    ram_waddr = (r_dv_idx > r_hi) ? r_dv_idx - IDX_W'(2)
                                                  : r_dv_idx - IDX_W'(1);
                    ram_wdata = rd_entry;
                end
                // put the new internal node at the front
                if (scan_end) begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(r_len - LEN_W'(2));
                    ram_wdata = '{id: r_next_id, cnt: r_res_count};
                    n_len     = r_len - LEN_W'(1);
                    n_next_id = (r_next_id == LAST_INTERNAL_ID) ? FIRST_INTERNAL_ID
                                                                : r_next_id + ID_W'(1);
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_new_id = r_res_new_id;
                    n_o_left   = r_res_left;
                    n_o_right  = r_res_right;
                    n_o_count  = out_count(r_res_count);
                    n_o_len    = OUT_LEN_W'(r_len);
                end
            end

            default: begin
                n_dv = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_next_id <= FIRST_INTERNAL_ID;
            r_dv      <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_next_id <= n_next_id;
            r_dv      <= n_dv;
            r_a_vld   <= n_a_vld;
            r_b_vld   <= n_b_vld;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_sym        <= n_sym;
        r_rd_idx     <= n_rd_idx;
        r_dv_idx     <= n_dv_idx;
        r_a_idx      <= n_a_idx;
        r_a_id       <= n_a_id;
        r_a_cnt      <= n_a_cnt;
        r_b_idx      <= n_b_idx;
        r_b_id       <= n_b_id;
        r_b_cnt      <= n_b_cnt;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_status <= n_res_status;
        r_res_new_id <= n_res_new_id;
        r_res_left   <= n_res_left;
        r_res_right  <= n_res_right;
        r_res_count  <= n_res_count;
        r_o_status   <= n_o_status;
        r_o_new_id   <= n_o_new_id;
        r_o_left     <= n_o_left;
        r_o_right    <= n_o_right;
        r_o_count    <= n_o_count;
        r_o_len      <= n_o_len;
    end

    // ports
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_new_id      = r_o_new_id;
    assign o_left_id     = r_o_left;
    assign o_right_id    = r_o_right;
    assign o_count       = r_o_count;
    assign o_list_length = r_o_len;

    // checks
    `include "assert_macros.svh"

    `HFM_ASSERT(a_len_bound, r_len <= LEN_W'(MAX_ENTRIES), "list length beyond capacity")
    `HFM_ASSERT_IMP(a_holes_ordered, r_state == S_SWEEP, r_lo < r_hi, "merge holes not distinct")
    `HFM_ASSERT_IMP(a_sweep_moves_down, r_state == S_SWEEP && r_dv && r_dv_idx != r_hi, ram_we && ram_waddr < r_dv_idx, "sweep write not below read")
    `HFM_ASSERT_IMP(a_result_from_done, $rose(r_o_valid), $past(r_state) == S_DONE, "result shown without finishing an item")

endmodule
